// ===== hw/rtl/ftn_pkg.sv =====
// ----------------------------------------------------------------------------
// ftn_pkg
// Shared widths, register indices and transfer structures of the fat tree
// neighbour calculator.
// ----------------------------------------------------------------------------
package ftn_pkg;

	localparam int NODE_W  = 21;
	localparam int SID_W   = 20;
	localparam int FAN_W   = 5;
	localparam int ID_W    = 24;
	localparam int NB_W    = 26;
	localparam int PIDX_W  = 4;
	localparam int PORT_W  = 5;
	localparam int LVL_W   = 20;
	localparam int CNT5_W  = 5;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int DEF_MAX_FANOUT = 16;

	localparam logic [NODE_W-1:0] NUM_NODES_RST    = NODE_W'(16);
	localparam logic [FAN_W-1:0]  FANOUT_RST       = FAN_W'(2);
	localparam logic [FAN_W-1:0]  FANOUT_MIN       = FAN_W'(2);
	localparam logic [ID_W-1:0]   SWITCH_START_RST = '0;
	localparam logic [ID_W-1:0]   NIC_START_RST    = '0;

	typedef enum logic [1:0] {
		REG_NUM_NODES    = 2'd0,
		REG_FANOUT       = 2'd1,
		REG_SWITCH_START = 2'd2,
		REG_NIC_START    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [NODE_W-1:0] num_nodes;
		logic [FAN_W-1:0]  fanout;
		logic [ID_W-1:0]   switch_start;
		logic [ID_W-1:0]   nic_start;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NODE_W-1:0] dividend;
		logic [NODE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [NODE_W-1:0] quo;
		logic [NODE_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic [FAN_W-1:0]  f;
		logic              valid;
		logic              top;
		logic [NB_W-1:0]   base_dn;
		logic [NB_W-1:0]   step_dn;
		logic [NB_W-1:0]   base_up;
		logic [NB_W-1:0]   step_up;
		logic [NODE_W-1:0] rs;
		logic [NODE_W-1:0] re;
		logic [PIDX_W-1:0] up;
		logic [PIDX_W-1:0] dn;
	} desc_t;

	typedef struct packed {
		logic              strobe;
		logic [PORT_W-1:0] port;
		logic [NB_W-1:0]   neighbour;
		logic              has_neighbour;
		logic [NODE_W-1:0] range_start;
		logic [NODE_W-1:0] range_end;
		logic [PIDX_W-1:0] up_port;
		logic [PIDX_W-1:0] down_port;
		logic              last;
	} res_t;

endpackage

// ===== hw/rtl/ftn_div.sv =====
// ----------------------------------------------------------------------------
// ftn_div
// Restoring divider, one quotient bit per cycle, shared by the front end.
// ----------------------------------------------------------------------------
module ftn_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ftn_pkg::div_req_t req,
	output ftn_pkg::div_rsp_t rsp
);
	import ftn_pkg::*;

	localparam int CW = $clog2(NODE_W + 1);

	logic [CW-1:0]     cnt_q;
	logic              run_q;
	logic [NODE_W-1:0] quo_q;
	logic [NODE_W:0]   rem_q;
	logic [NODE_W-1:0] div_q;
	logic [NODE_W:0]   rem_sh;
	logic              ge;
	logic              done_q;

	assign rem_sh = {rem_q[NODE_W-1:0], quo_q[NODE_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= CW'(NODE_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[NODE_W-2:0], ge};
			rem_q <= ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
		end
	end

	// The result is complete once the count has run out; done marks that cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && (cnt_q == CW'(1));
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[NODE_W-1:0];

endmodule

// ===== hw/rtl/ftn_front.sv =====
// ----------------------------------------------------------------------------
// ftn_front
// Accepts a switch number and works out its level, position, node range and
// neighbour bases with a sequencer around the shared divider.
// ----------------------------------------------------------------------------
module ftn_front #(
	parameter int MAX_FANOUT = ftn_pkg::DEF_MAX_FANOUT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ftn_pkg::cfg_t             cfg,
	input  logic                      start,
	input  logic [ftn_pkg::SID_W-1:0] switch_id,
	output logic                      busy,
	output ftn_pkg::desc_t            desc,
	output logic                      push,
	input  logic                      q_full
);
	import ftn_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DLSW  = 16'h0002,
		S_WLSW  = 16'h0004,
		S_DLVL  = 16'h0008,
		S_WLVL  = 16'h0010,
		S_POW   = 16'h0020,
		S_DDIM  = 16'h0040,
		S_WDIM  = 16'h0080,
		S_DUP   = 16'h0100,
		S_WUP   = 16'h0200,
		S_DDN   = 16'h0400,
		S_WDN   = 16'h0800,
		S_MUL1  = 16'h1000,
		S_MUL2  = 16'h2000,
		S_BUILD = 16'h4000,
		S_PUSH  = 16'h8000
	} state_t;

	state_t            state_q;
	div_req_t          dreq;
	div_rsp_t          drsp;
	logic              ddone;

	logic [FAN_W-1:0]  f_q;
	logic [SID_W-1:0]  sid_q;
	logic [NODE_W-1:0] lsw_q;
	logic [LVL_W-1:0]  level_q;
	logic [NODE_W-1:0] cur_q;
	logic [NB_W-1:0]   p_q;
	logic [CNT5_W-1:0] k_q;
	logic [CNT5_W-1:0] nl_q;
	logic [NODE_W-1:0] d_q;
	logic [NODE_W-1:0] sub_q;
	logic              valid_q;
	logic              top_q;
	logic [NODE_W-1:0] dim_q;
	logic [NODE_W-1:0] off_q;
	logic [PIDX_W-1:0] up_q;
	logic [PIDX_W-1:0] dn_q;
	logic [NB_W-1:0]   prod_a_q;
	logic [NB_W-1:0]   prod_b_q;
	logic [NB_W-1:0]   prod_c_q;
	logic [NB_W-1:0]   prod_d_q;
	logic [NB_W-1:0]   prod_e_q;
	desc_t             desc_q;

	logic [FAN_W-1:0]  f_sat;
	logic              pow_go;
	logic [NODE_W-1:0] lvl_p1;
	logic              valid_n;
	logic              top_n;

	always_comb begin
		if (cfg.fanout < FANOUT_MIN) begin
			f_sat = FANOUT_MIN;
		end else if (32'(cfg.fanout) > MAX_FANOUT) begin
			f_sat = FAN_W'(MAX_FANOUT);
		end else begin
			f_sat = cfg.fanout;
		end
	end

	assign pow_go  = p_q <= NB_W'(cfg.num_nodes);
	assign lvl_p1  = NODE_W'(level_q) + NODE_W'(1);
	assign valid_n = lvl_p1 < NODE_W'(nl_q);
	assign top_n   = (lvl_p1 + NODE_W'(1)) == NODE_W'(nl_q);

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = '0;
		dreq.divisor  = NODE_W'(1);
		case (state_q)
			S_DLSW: begin
				dreq.start    = 1'b1;
				dreq.dividend = cfg.num_nodes;
				dreq.divisor  = NODE_W'(f_q);
			end
			S_DLVL: begin
				dreq.start    = 1'b1;
				dreq.dividend = NODE_W'(sid_q);
				dreq.divisor  = lsw_q;
			end
			S_DDIM: begin
				dreq.start    = 1'b1;
				dreq.dividend = cur_q;
				dreq.divisor  = d_q;
			end
			S_DUP: begin
				dreq.start    = 1'b1;
				dreq.dividend = dim_q;
				dreq.divisor  = NODE_W'(f_q);
			end
			S_DDN: begin
				dreq.start    = 1'b1;
				dreq.dividend = off_q;
				dreq.divisor  = sub_q;
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	ftn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign ddone = drsp.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (start) state_q <= S_DLSW;
				S_DLSW:  state_q <= S_WLSW;
				S_WLSW:  if (ddone) state_q <= S_DLVL;
				S_DLVL:  state_q <= S_WLVL;
				S_WLVL:  if (ddone) state_q <= S_POW;
				S_POW:   if (!pow_go) state_q <= valid_n ? S_DDIM : S_BUILD;
				S_DDIM:  state_q <= S_WDIM;
				S_WDIM:  if (ddone) state_q <= S_DUP;
				S_DUP:   state_q <= S_WUP;
				S_WUP:   if (ddone) state_q <= (level_q != '0) ? S_DDN : S_MUL1;
				S_DDN:   state_q <= S_WDN;
				S_WDN:   if (ddone) state_q <= S_MUL1;
				S_MUL1:  state_q <= S_MUL2;
				S_MUL2:  state_q <= S_BUILD;
				S_BUILD: state_q <= S_PUSH;
				S_PUSH:  if (!q_full) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sid_q <= switch_id;
				f_q   <= f_sat;
			end
			S_WLSW: begin
				lsw_q <= (drsp.quo == '0) ? NODE_W'(1) : drsp.quo;
			end
			S_WLVL: begin
				level_q <= drsp.quo[LVL_W-1:0];
				cur_q   <= drsp.rem;
				p_q     <= NB_W'(1);
				k_q     <= '0;
				nl_q    <= '0;
			end
			S_POW: begin
				if (LVL_W'(k_q) == level_q) d_q <= p_q[NODE_W-1:0];
				if (LVL_W'(k_q) + LVL_W'(1) == level_q) sub_q <= p_q[NODE_W-1:0];
				if (pow_go) begin
					p_q  <= NB_W'(p_q * f_q);
					k_q  <= k_q + 1'b1;
					nl_q <= nl_q + 1'b1;
				end else begin
					valid_q <= valid_n;
					top_q   <= top_n;
				end
			end
			S_WDIM: begin
				dim_q <= drsp.quo;
				off_q <= drsp.rem;
			end
			S_WUP: begin
				up_q <= drsp.rem[PIDX_W-1:0];
				dn_q <= '0;
			end
			S_WDN: begin
				dn_q <= drsp.quo[PIDX_W-1:0];
			end
			S_MUL1: begin
				prod_a_q <= NB_W'(level_q) * NB_W'(lsw_q);
				prod_b_q <= NB_W'(cur_q - off_q) * NB_W'(f_q);
			end
			S_MUL2: begin
				prod_c_q <= NB_W'(up_q * d_q);
				prod_d_q <= NB_W'(dn_q * sub_q);
				prod_e_q <= NB_W'(d_q * f_q);
			end
			S_BUILD: begin
				desc_q.f     <= f_q;
				desc_q.valid <= valid_q;
				desc_q.top   <= top_q;
				if (valid_q) begin
					desc_q.rs <= prod_b_q[NODE_W-1:0];
					desc_q.re <= NODE_W'(prod_b_q + prod_e_q);
					desc_q.up <= up_q;
					desc_q.dn <= dn_q;
					if (level_q == '0) begin
						desc_q.base_dn <= prod_b_q + NB_W'(cfg.nic_start);
						desc_q.step_dn <= NB_W'(1);
					end else begin
						desc_q.base_dn <= NB_W'(cfg.switch_start) + prod_a_q
							- NB_W'(lsw_q) + NB_W'(cur_q) - prod_d_q;
						desc_q.step_dn <= NB_W'(sub_q);
					end
					desc_q.base_up <= NB_W'(cfg.switch_start) + prod_a_q
						+ NB_W'(lsw_q) + NB_W'(cur_q) - prod_c_q;
					desc_q.step_up <= NB_W'(d_q);
				end else begin
					desc_q.rs      <= '0;
					desc_q.re      <= '0;
					desc_q.up      <= '0;
					desc_q.dn      <= '0;
					desc_q.base_dn <= '0;
					desc_q.step_dn <= '0;
					desc_q.base_up <= '0;
					desc_q.step_up <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign push = (state_q == S_PUSH) && !q_full;
	assign desc = desc_q;

endmodule

// ===== hw/rtl/ftn_queue.sv =====
// ----------------------------------------------------------------------------
// ftn_queue
// Two-entry queue of switch descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module ftn_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ftn_pkg::desc_t wdata,
	input  logic           pop,
	output ftn_pkg::desc_t rdata,
	output logic           full,
	output logic           empty
);
	import ftn_pkg::*;

	desc_t      mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	assign rdata = mem_q[rd_q];
	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;

endmodule

// ===== hw/rtl/ftn_back.sv =====
// ----------------------------------------------------------------------------
// ftn_back
// Walks the ports of one switch descriptor, one result per cycle.
// ----------------------------------------------------------------------------
module ftn_back #(
	parameter int MAX_FANOUT = ftn_pkg::DEF_MAX_FANOUT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ftn_pkg::desc_t qdesc,
	input  logic           q_empty,
	output logic           pop,
	output ftn_pkg::res_t  res
);
	import ftn_pkg::*;

	localparam int CNT_W = $clog2(2 * MAX_FANOUT);

	logic            act_q;
	logic [CNT_W-1:0] i_q;
	desc_t           dsc_q;
	logic [NB_W-1:0] nbd_q;
	logic [NB_W-1:0] nbu_q;
	logic            down;
	logic            last;
	logic [FAN_W:0]  nports;

	assign nports = {dsc_q.f, 1'b0} - (FAN_W+1)'(1);
	assign down   = i_q < CNT_W'(dsc_q.f);
	assign last   = i_q == CNT_W'(nports);
	assign pop    = !q_empty && (!act_q || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else if (pop) begin
			act_q <= 1'b1;
		end else if (last) begin
			act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dsc_q <= qdesc;
			i_q   <= '0;
			nbd_q <= qdesc.base_dn;
			nbu_q <= qdesc.base_up;
		end else if (act_q) begin
			i_q <= i_q + 1'b1;
			if (down) begin
				nbd_q <= nbd_q + dsc_q.step_dn;
			end else begin
				nbu_q <= nbu_q + dsc_q.step_up;
			end
		end
	end

	always_comb begin
		res.strobe        = act_q;
		res.port          = PORT_W'(i_q);
		res.has_neighbour = dsc_q.valid && (down || !dsc_q.top);
		res.neighbour     = res.has_neighbour ? (down ? nbd_q : nbu_q) : '0;
		res.range_start   = dsc_q.rs;
		res.range_end     = dsc_q.re;
		res.up_port       = dsc_q.up;
		res.down_port     = dsc_q.dn;
		res.last          = last;
	end

endmodule

// ===== hw/rtl/fat_tree_neighbour_calc.sv =====
// ----------------------------------------------------------------------------
// fat_tree_neighbour_calc
// Lists the port connectivity of one switch of a fanout-ary fat tree.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// command   start / busy              switch_id
// result    strobe (one cycle)        port, neighbour, has_neighbour,
//                                     range_start, range_end, up_port,
//                                     down_port, last
// config    APB psel/penable/pwrite   paddr, pwdata, prdata
//
// The front end works out one switch at a time, with two to five passes of
// the shared divider and the level power loop.
// The back end then gives 2*fanout results on consecutive cycles.
// A two-entry queue lets the next command be worked while results stream out;
// when it is full the front end holds its descriptor and busy stays high.
// Reset clears all control state and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module fat_tree_neighbour_calc #(
	parameter int MAX_FANOUT = ftn_pkg::DEF_MAX_FANOUT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [ftn_pkg::SID_W-1:0]   switch_id,
	output logic                        strobe,
	output logic [ftn_pkg::PORT_W-1:0]  port,
	output logic [ftn_pkg::NB_W-1:0]    neighbour,
	output logic                        has_neighbour,
	output logic [ftn_pkg::NODE_W-1:0]  range_start,
	output logic [ftn_pkg::NODE_W-1:0]  range_end,
	output logic [ftn_pkg::PIDX_W-1:0]  up_port,
	output logic [ftn_pkg::PIDX_W-1:0]  down_port,
	output logic                        last,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ftn_pkg::ADDR_W-1:0]  paddr,
	input  logic [ftn_pkg::DATA_W-1:0]  pwdata,
	output logic [ftn_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import ftn_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t ridx;
	logic     wr_en;
	logic     front_busy;
	desc_t    f_desc;
	desc_t    q_desc;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_empty;
	res_t     res;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_nodes    <= NUM_NODES_RST;
			cfg_q.fanout       <= FANOUT_RST;
			cfg_q.switch_start <= SWITCH_START_RST;
			cfg_q.nic_start    <= NIC_START_RST;
		end else if (wr_en) begin
			case (ridx)
				REG_NUM_NODES:    cfg_q.num_nodes    <= pwdata[NODE_W-1:0];
				REG_FANOUT:       cfg_q.fanout       <= pwdata[FAN_W-1:0];
				REG_SWITCH_START: cfg_q.switch_start <= pwdata[ID_W-1:0];
				REG_NIC_START:    cfg_q.nic_start    <= pwdata[ID_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_NUM_NODES:    prdata = DATA_W'(cfg_q.num_nodes);
			REG_FANOUT:       prdata = DATA_W'(cfg_q.fanout);
			REG_SWITCH_START: prdata = DATA_W'(cfg_q.switch_start);
			REG_NIC_START:    prdata = DATA_W'(cfg_q.nic_start);
			default:          prdata = '0;
		endcase
	end

	ftn_front #(.MAX_FANOUT(MAX_FANOUT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.switch_id (switch_id),
		.busy      (front_busy),
		.desc      (f_desc),
		.push      (push),
		.q_full    (q_full)
	);

	ftn_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_desc),
		.pop    (pop),
		.rdata  (q_desc),
		.full   (q_full),
		.empty  (q_empty)
	);

	ftn_back #(.MAX_FANOUT(MAX_FANOUT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qdesc   (q_desc),
		.q_empty (q_empty),
		.pop     (pop),
		.res     (res)
	);

	assign busy          = front_busy;
	assign strobe        = res.strobe;
	assign port          = res.port;
	assign neighbour     = res.neighbour;
	assign has_neighbour = res.has_neighbour;
	assign range_start   = res.range_start;
	assign range_end     = res.range_end;
	assign up_port       = res.up_port;
	assign down_port     = res.down_port;
	assign last          = res.last;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the fat tree neighbour calculator against a built-in predictor.
// A set of fixed switch numbers and tree shapes comes first, with out-of-range
// fanout, trees smaller than one fanout, empty trees and switches past the top
// level. Random tree shapes and switch numbers follow. Every port result is
// compared field by field, in order, with the predicted results.
// ----------------------------------------------------------------------------
module tb_top;

	import ftn_pkg::*;

	localparam int MAX_FANOUT = DEF_MAX_FANOUT;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [SID_W-1:0]    switch_id;
	logic                strobe;
	logic [PORT_W-1:0]   port;
	logic [NB_W-1:0]     neighbour;
	logic                has_neighbour;
	logic [NODE_W-1:0]   range_start;
	logic [NODE_W-1:0]   range_end;
	logic [PIDX_W-1:0]   up_port;
	logic [PIDX_W-1:0]   down_port;
	logic                last;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	cfg_t                tree_cfg;
	logic [SID_W-1:0]    switch_q[$];
	res_t                port_q[$];
	int                  idle_pct;
	bit                  hold_off;
	int                  err_cnt;
	int                  switch_cnt;
	int                  port_cnt;
	int                  cfg_cnt;

	fat_tree_neighbour_calc #(.MAX_FANOUT(MAX_FANOUT)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .switch_id(switch_id),
		.strobe(strobe), .port(port), .neighbour(neighbour), .has_neighbour(has_neighbour),
		.range_start(range_start), .range_end(range_end), .up_port(up_port),
		.down_port(down_port), .last(last), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint unsigned eff_fanout();
		longint unsigned f;
		f = tree_cfg.fanout;
		if (f < 2) f = 2;
		if (f > MAX_FANOUT) f = MAX_FANOUT;
		return f;
	endfunction

	function automatic longint unsigned level_count();
		longint unsigned f, tmp, nl;
		f = eff_fanout();
		tmp = tree_cfg.num_nodes;
		nl = 0;
		while (tmp != 0) begin
			tmp = tmp / f;
			nl++;
		end
		return nl;
	endfunction

	function automatic longint unsigned per_level();
		longint unsigned lsw;
		lsw = tree_cfg.num_nodes / eff_fanout();
		if (lsw == 0) lsw = 1;
		return lsw;
	endfunction

	function automatic void predict_ports(logic [SID_W-1:0] sid);
		longint unsigned f, lsw, lvl, cur, nl, d, dim, off, rs, re, up, dn, sub, nb;
		bit ok, top, has;
		res_t r;
		f = eff_fanout();
		lsw = per_level();
		lvl = sid / lsw;
		cur = sid % lsw;
		nl = level_count();
		ok = (lvl + 1) < nl;
		top = (lvl + 2) == nl;
		d = 1; dim = 0; off = 0; rs = 0; re = 0; up = 0; dn = 0; sub = 1;
		if (ok) begin
			for (longint unsigned i = 0; i < lvl; i++) d = d * f;
			off = cur % d;
			dim = cur / d;
			rs = dim * d * f;
			re = (dim + 1) * d * f;
			up = (cur % (d * f)) / d;
			if (lvl != 0) begin
				sub = d / f;
				dn = off / sub;
			end
		end
		for (longint unsigned i = 0; i < 2 * f; i++) begin
			nb = 0;
			has = 1'b0;
			if (ok) begin
				if (i < f) begin
					has = 1'b1;
					if (lvl == 0) nb = cur * f + i + tree_cfg.nic_start;
					else nb = tree_cfg.switch_start + (lvl - 1) * lsw + dim * d + i * sub
						+ off % sub;
				end else if (!top) begin
					has = 1'b1;
					nb = tree_cfg.switch_start + (lvl + 1) * lsw + (cur / (d * f)) * (d * f)
						+ (i - f) * d + off;
				end
			end
			r.strobe        = 1'b1;
			r.port          = PORT_W'(i);
			r.neighbour     = NB_W'(nb);
			r.has_neighbour = has;
			r.range_start   = NODE_W'(rs);
			r.range_end     = NODE_W'(re);
			r.up_port       = PIDX_W'(up);
			r.down_port     = PIDX_W'(dn);
			r.last          = (i + 1 == 2 * f);
			port_q.push_back(r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : drv_p
		bit take;
		if (!arst_n) begin
			start     <= 1'b0;
			switch_id <= '0;
		end else begin
			take = !start;
			if (start && !busy) begin
				predict_ports(switch_id);
				switch_cnt++;
				take = 1'b1;
			end
			if (take) begin
				if (switch_q.size() > 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
					switch_id <= switch_q.pop_front();
					start     <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : mon_p
		res_t e;
		if (arst_n && strobe) begin
			port_cnt++;
			if (port_q.size() == 0) begin
				$error("unexpected port result, port %0d", port);
				err_cnt++;
			end else begin
				e = port_q.pop_front();
				if (port !== e.port) begin
					$error("port: expected %0d, got %0d", e.port, port);
					err_cnt++;
				end
				if (neighbour !== e.neighbour) begin
					$error("neighbour: expected %0d, got %0d", e.neighbour, neighbour);
					err_cnt++;
				end
				if (has_neighbour !== e.has_neighbour) begin
					$error("has_neighbour: expected %0d, got %0d", e.has_neighbour,
						has_neighbour);
					err_cnt++;
				end
				if (range_start !== e.range_start) begin
					$error("range_start: expected %0d, got %0d", e.range_start, range_start);
					err_cnt++;
				end
				if (range_end !== e.range_end) begin
					$error("range_end: expected %0d, got %0d", e.range_end, range_end);
					err_cnt++;
				end
				if (up_port !== e.up_port) begin
					$error("up_port: expected %0d, got %0d", e.up_port, up_port);
					err_cnt++;
				end
				if (down_port !== e.down_port) begin
					$error("down_port: expected %0d, got %0d", e.down_port, down_port);
					err_cnt++;
				end
				if (last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, last);
					err_cnt++;
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'(4 * int'(idx));
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_NUM_NODES:    tree_cfg.num_nodes    = val[NODE_W-1:0];
			REG_FANOUT:       tree_cfg.fanout       = val[FAN_W-1:0];
			REG_SWITCH_START: tree_cfg.switch_start = val[ID_W-1:0];
			REG_NIC_START:    tree_cfg.nic_start    = val[ID_W-1:0];
			default: ;
		endcase
		cfg_cnt++;
	endtask

	task automatic wait_drained();
		while (switch_q.size() != 0 || start || port_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_tree(logic [DATA_W-1:0] nn, logic [DATA_W-1:0] f,
		logic [DATA_W-1:0] ss, logic [DATA_W-1:0] ns);
		wait_drained();
		reg_write(REG_NUM_NODES, nn);
		reg_write(REG_FANOUT, f);
		reg_write(REG_SWITCH_START, ss);
		reg_write(REG_NIC_START, ns);
	endtask

	// Mostly switches inside the tree, the rest anywhere in the id space.
	task automatic queue_random(int n);
		longint unsigned span;
		span = (level_count() > 1) ? (level_count() - 1) * per_level() : 0;
		if (span > (1 << SID_W)) span = 1 << SID_W;
		for (int i = 0; i < n; i++) begin
			if (span > 0 && $urandom_range(99) < 85)
				switch_q.push_back(SID_W'($urandom_range(int'(span - 1))));
			else
				switch_q.push_back(SID_W'($urandom));
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		idle_pct = 0;
		hold_off = 1'b0;
		err_cnt  = 0;
		switch_cnt = 0;
		port_cnt = 0;
		cfg_cnt  = 0;
		tree_cfg = '{num_nodes: NUM_NODES_RST, fanout: FANOUT_RST,
			switch_start: SWITCH_START_RST, nic_start: NIC_START_RST};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		switch_q = '{20'd0, 20'd7, 20'd8, 20'd23, 20'd24, 20'd31, 20'd32, 20'hFFFFF};
		set_tree(32'd27, 32'd3, 32'hFFFFFF, 32'hFFFFFF);
		switch_q = '{20'd0, 20'd8, 20'd9, 20'd17, 20'd18};
		set_tree(32'd256, 32'd0, 32'd100, 32'd5);
		switch_q = '{20'd0, 20'd200, 20'd1000};
		set_tree(32'd65536, 32'd31, 32'd7, 32'd9);
		switch_q = '{20'd0, 20'd4095, 20'd8191, 20'd12287};
		set_tree(32'd3, 32'd4, 32'd1, 32'd2);
		switch_q = '{20'd0, 20'd1};
		set_tree(32'd16, 32'd16, 32'd0, 32'd0);
		switch_q = '{20'd0, 20'd1};
		set_tree(32'h1FFFFF, 32'd2, 32'hABCDEF, 32'h123456);
		switch_q = '{20'd0, 20'hFFFFF, 20'd1048575 - 20'd1};
		set_tree(32'd0, 32'd17, 32'd3, 32'd3);
		switch_q = '{20'd0};

		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 76;
				2: idle_pct = 0;
				default: idle_pct = 17;
			endcase
			case ($urandom_range(3))
				0: set_tree($urandom_range(1, 64), $urandom_range(31), $urandom, $urandom);
				1: set_tree($urandom_range(1, 4096), $urandom_range(2, 16), $urandom, $urandom);
				2: set_tree($urandom_range(1, 1 << 20), $urandom_range(2, 8), $urandom, $urandom);
				default: set_tree($urandom, $urandom, $urandom, $urandom);
			endcase
			queue_random(12);
			if (ph == 5) begin
				while (switch_q.size() > 6) @(posedge clk);
				hold_off = 1'b1;
				while (start || port_q.size() != 0) @(posedge clk);
				hold_off = 1'b0;
			end
			queue_random(12);
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("Covered %0d switches, %0d port results, %0d register writes.",
			switch_cnt, port_cnt, cfg_cnt);
		$display("Tree shapes included out-of-range fanout, empty and tiny trees.");
		if (err_cnt == 0 && port_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (port_q.size() != 0) $error("%0d port results never arrived", port_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#(4 * 1500000);
		$display("TB_ERROR");
		$finish;
	end

endmodule
